// ----- hw/rtl/efd_pkg.sv -----
// Shared types and constants for the escaped frame decoder.
package efd_pkg;

  // Number of decoded bytes that form the frame header.
  localparam int HDR_BYTES = 8;
  localparam int HDR_CNT_W = $clog2(HDR_BYTES + 1);
  localparam int HDR_IDX_W = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;

  // Header bytes that the summary fields are built from.
  localparam int HDR_VIEW = 8;

  // Escape byte and the offset taken off the byte that follows it.
  localparam logic [7:0] ESC_BYTE   = 8'h10;
  localparam logic [7:0] ESC_OFFSET = 8'h20;

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command passed from the front to the back.
  typedef enum logic {
    CMD_BODY = 1'b0,
    CMD_END  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       held_valid;
    logic [7:0] data;
  } efd_cmd_t;

  // Result kind on the output channel.
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } res_kind_t;

  // Write side of the queue.
  typedef struct packed {
    logic     push;
    efd_cmd_t cmd;
  } efd_q_wr_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } efd_q_stat_t;

endpackage

// ----- hw/rtl/efd_if.sv -----
// Channel interfaces for raw input bytes and decoded results.
interface efd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink   (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface efd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  peripheral_id;
  logic [7:0]  protocol_id;
  logic [15:0] serial_key;
  logic [15:0] sequence_number;
  logic [7:0]  message_type;
  logic [7:0]  type_index;
  logic        checksum_bad;
  logic        escape_dangling;
  logic        too_short;
  logic        last;

  modport source (
    output valid, output kind, output payload_byte, output peripheral_id,
    output protocol_id, output serial_key, output sequence_number,
    output message_type, output type_index, output checksum_bad,
    output escape_dangling, output too_short, output last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input peripheral_id,
    input protocol_id, input serial_key, input sequence_number,
    input message_type, input type_index, input checksum_bad,
    input escape_dangling, input too_short, input last, output ready
  );
endinterface

// ----- hw/rtl/escaped_frame_decoder.sv -----
// Top level of the escaped frame decoder.
// The in_ch channel takes one raw received byte per beat, with frame_last set
// on the end marker. The first byte of a frame is dropped as the start marker
// and the byte just before the end marker is the checksum; the body is
// unescaped, the first eight decoded bytes form the header and every later
// decoded byte leaves on out_ch as a payload beat. The end marker produces one
// summary beat with the header fields and the error flags.
// One byte is accepted per cycle while the command queue has a free slot. A body
// byte is held until the next byte arrives; the command it causes is pushed into
// the queue when that next byte is accepted and then read into the output register.
// The front end and back end are decoupled by a four-entry command queue, so
// in_ch.ready drops only when that queue is full, which happens when the
// receiver stalls out_ch while input keeps arriving.
// The output register holds its beat stable until out_ch.ready is high.
// Synchronous reset clears all frame state, the queue and the output valid.
module escaped_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  efd_in_if.sink     in_ch,
  efd_out_if.source  out_ch
);

  efd_pkg::efd_q_wr_t   q_wr;
  efd_pkg::efd_q_stat_t q_stat;
  efd_pkg::efd_cmd_t    rd_cmd;
  logic                 pop;

  efd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  efd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .q_stat (q_stat)
  );

  efd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (rd_cmd),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hw/rtl/efd_front.sv -----
// Front end: drops the start marker, holds back one body byte and issues commands.
module efd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  efd_in_if.sink               in_ch,
  input  efd_pkg::efd_q_stat_t q_stat,
  output efd_pkg::efd_q_wr_t   q_wr
);

  logic       start_seen_r, start_seen_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       beat;

  // Every beat may need a queue slot, so take one only when a slot is free.
  assign in_ch.ready = !q_stat.full;
  assign beat        = in_ch.valid && in_ch.ready;

  // Classify the beat and release the held byte when a later byte arrives.
  always_comb begin
    start_seen_nxt = start_seen_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    q_wr.push           = 1'b0;
    q_wr.cmd.kind       = efd_pkg::CMD_BODY;
    q_wr.cmd.held_valid = held_valid_r;
    q_wr.cmd.data       = held_byte_r;
    if (beat) begin
      if (in_ch.frame_last) begin
        q_wr.push      = 1'b1;
        q_wr.cmd.kind  = efd_pkg::CMD_END;
        start_seen_nxt = 1'b0;
        held_valid_nxt = 1'b0;
        held_byte_nxt  = 8'h00;
      end else if (!start_seen_r) begin
        start_seen_nxt = 1'b1;
      end else begin
        q_wr.push      = held_valid_r;
        held_byte_nxt  = in_ch.rx_byte;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // Frame tracking registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seen_r <= 1'b0;
      held_valid_r <= 1'b0;
      held_byte_r  <= 8'h00;
    end else begin
      start_seen_r <= start_seen_nxt;
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
    end
  end

endmodule

// ----- hw/rtl/efd_queue.sv -----
// Short command queue between the front and back ends.
module efd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efd_pkg::efd_q_wr_t   q_wr,
  input  logic                 pop,
  output efd_pkg::efd_cmd_t    rd_cmd,
  output efd_pkg::efd_q_stat_t q_stat
);

  efd_pkg::efd_cmd_t             slot_r [efd_pkg::Q_DEPTH];
  logic [efd_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [efd_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [efd_pkg::Q_CNT_W-1:0]   count_r, count_nxt;
  logic                          do_push, do_pop;

  assign q_stat.full  = (count_r == efd_pkg::Q_CNT_W'(efd_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_cmd       = slot_r[rd_ptr_r];

  // Pointer and fill count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == efd_pkg::Q_PTR_W'(efd_pkg::Q_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == efd_pkg::Q_PTR_W'(efd_pkg::Q_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= efd_pkg::Q_CNT_W'(efd_pkg::Q_DEPTH))
    else $error("queue count above depth");

  // The count goes up by one on a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ----- hw/rtl/efd_back.sv -----
// Back end: checksum, unescaping, header capture and the output register.
module efd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efd_pkg::efd_cmd_t    cmd,
  input  efd_pkg::efd_q_stat_t q_stat,
  output logic                 pop,
  efd_out_if.source            out_ch
);

  logic [7:0]                    sum_r, sum_nxt;
  logic                          esc_r, esc_nxt;
  logic [efd_pkg::HDR_CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [7:0]                    hdr_r   [efd_pkg::HDR_BYTES];
  logic [7:0]                    hdr_nxt [efd_pkg::HDR_BYTES];
  logic [7:0]                    view    [efd_pkg::HDR_VIEW];

  logic        ov_r, ov_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  pay_r, pay_nxt;
  logic        cks_r, cks_nxt;
  logic        dang_r, dang_nxt;
  logic        short_r, short_nxt;
  logic [7:0]  v_r   [efd_pkg::HDR_VIEW];
  logic [7:0]  v_nxt [efd_pkg::HDR_VIEW];

  logic        have;
  logic [7:0]  dec;
  logic        hdr_full;

  // Header bytes past the configured header length read as zero.
  for (genvar i = 0; i < efd_pkg::HDR_VIEW; i++) begin : g_view
    if (i < efd_pkg::HDR_BYTES) begin : g_on
      assign view[i] = hdr_r[i];
    end else begin : g_off
      assign view[i] = 8'h00;
    end
  end

  assign pop      = !q_stat.empty && (!ov_r || out_ch.ready);
  assign hdr_full = (hcnt_r == efd_pkg::HDR_CNT_W'(efd_pkg::HDR_BYTES));

  // Unescape the body byte of the current command.
  always_comb begin
    have = 1'b1;
    dec  = cmd.data;
    if (esc_r) begin
      dec = cmd.data - efd_pkg::ESC_OFFSET;
    end else if (cmd.data == efd_pkg::ESC_BYTE) begin
      have = 1'b0;
    end
  end

  // Frame state and output register next values.
  always_comb begin
    sum_nxt   = sum_r;
    esc_nxt   = esc_r;
    hcnt_nxt  = hcnt_r;
    hdr_nxt   = hdr_r;
    ov_nxt    = ov_r && !out_ch.ready;
    kind_nxt  = kind_r;
    pay_nxt   = pay_r;
    cks_nxt   = cks_r;
    dang_nxt  = dang_r;
    short_nxt = short_r;
    v_nxt     = v_r;
    if (pop) begin
      if (cmd.kind == efd_pkg::CMD_END) begin
        // Summary of the frame, then clear for the next one.
        ov_nxt    = 1'b1;
        kind_nxt  = efd_pkg::KIND_SUMMARY;
        pay_nxt   = 8'h00;
        cks_nxt   = cmd.held_valid ? (cmd.data != sum_r) : 1'b1;
        dang_nxt  = esc_r;
        short_nxt = !hdr_full;
        v_nxt     = view;
        sum_nxt   = 8'h00;
        esc_nxt   = 1'b0;
        hcnt_nxt  = '0;
        for (int i = 0; i < efd_pkg::HDR_BYTES; i++) begin
          hdr_nxt[i] = 8'h00;
        end
      end else begin
        sum_nxt = sum_r + cmd.data;
        esc_nxt = !esc_r && (cmd.data == efd_pkg::ESC_BYTE);
        if (have) begin
          if (!hdr_full) begin
            hdr_nxt[hcnt_r[efd_pkg::HDR_IDX_W-1:0]] = dec;
            hcnt_nxt = hcnt_r + 1'b1;
          end else begin
            ov_nxt    = 1'b1;
            kind_nxt  = efd_pkg::KIND_PAYLOAD;
            pay_nxt   = dec;
            cks_nxt   = 1'b0;
            dang_nxt  = 1'b0;
            short_nxt = 1'b0;
            v_nxt     = view;
          end
        end
      end
    end
  end

  // Frame state and output valid are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= 8'h00;
      esc_r  <= 1'b0;
      hcnt_r <= '0;
      ov_r   <= 1'b0;
      for (int i = 0; i < efd_pkg::HDR_BYTES; i++) begin
        hdr_r[i] <= 8'h00;
      end
    end else begin
      sum_r  <= sum_nxt;
      esc_r  <= esc_nxt;
      hcnt_r <= hcnt_nxt;
      ov_r   <= ov_nxt;
      hdr_r  <= hdr_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    pay_r   <= pay_nxt;
    cks_r   <= cks_nxt;
    dang_r  <= dang_nxt;
    short_r <= short_nxt;
    v_r     <= v_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.payload_byte    = pay_r;
  assign out_ch.peripheral_id   = v_r[0];
  assign out_ch.protocol_id     = v_r[1];
  assign out_ch.serial_key      = {v_r[3], v_r[2]};
  assign out_ch.sequence_number = {v_r[5], v_r[4]};
  assign out_ch.message_type    = v_r[6];
  assign out_ch.type_index      = v_r[7];
  assign out_ch.checksum_bad    = cks_r;
  assign out_ch.escape_dangling = dang_r;
  assign out_ch.too_short       = short_r;
  assign out_ch.last            = (kind_r == efd_pkg::KIND_SUMMARY);

  // An end command always yields a summary beat in the next cycle.
  a_end_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.kind == efd_pkg::CMD_END) |=> (ov_r && kind_r == efd_pkg::KIND_SUMMARY))
    else $error("end command produced no summary");

  // The frame state is clear after a summary is produced.
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.kind == efd_pkg::CMD_END) |=> (hcnt_r == '0 && sum_r == 8'h00 && !esc_r))
    else $error("frame state not cleared after end");

  // A payload beat is only produced once the header is complete.
  a_payload_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cmd.kind == efd_pkg::CMD_BODY && !hdr_full)
      |=> !(ov_r && !$past(ov_r && !out_ch.ready) && kind_r == efd_pkg::KIND_PAYLOAD))
    else $error("payload produced before header complete");

endmodule

// ----- tb/escaped_frame_decoder_test.sv -----
// Self-checking testbench for the escaped frame decoder: directed frames, then random frames.
`timescale 1ns / 100ps

module escaped_frame_decoder_test;

  localparam int RAND_BEATS   = 1720;
  localparam int CALM_BEATS   = 200;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SHOWN_MAX    = 10;

  localparam logic [7:0] START_MARK = 8'h01;
  localparam logic [7:0] END_MARK   = 8'h04;

  // One decoded beat on the result channel.
  typedef struct {
    efd_pkg::res_kind_t kind;
    logic [7:0]  payload_byte;
    logic [7:0]  peripheral_id;
    logic [7:0]  protocol_id;
    logic [15:0] serial_key;
    logic [15:0] sequence_number;
    logic [7:0]  message_type;
    logic [7:0]  type_index;
    logic        checksum_bad;
    logic        escape_dangling;
    logic        too_short;
    logic        last;
  } frame_res_t;

  // One raw byte to send, with an optional hand-written summary.
  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_last;
    bit         typed;
    frame_res_t want;
  } rx_beat_t;

  // Directed row. For summaries of short frames the peripheral id and the
  // three error flags are given here; all other header fields are zero.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_last;
    logic       typed;
    logic [7:0] pid;
    logic       bad_sum;
    logic       dangling;
    logic       short_hdr;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // End marker straight after reset, with no start byte.
    {END_MARK,          1'b1, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1},
    // Start marker followed at once by the end marker: no checksum at all.
    {START_MARK,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {END_MARK,          1'b1, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1},
    // Full header with extreme values and escapes, one payload byte, good sum.
    {START_MARK,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hFF,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {efd_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h30,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {efd_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {efd_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {efd_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h7F,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h80,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h55,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hAA,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h6D,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {END_MARK,          1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    // Escape as the last body byte, with odd marker values.
    {8'h00,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {efd_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h10,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'hFF,             1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1},
    // Short frame with a wrong checksum.
    {START_MARK,        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h05,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {8'h00,             1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    {END_MARK,          1'b1, 1'b1, 8'h05, 1'b1, 1'b0, 1'b1}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  efd_in_if  in_ch ();
  efd_out_if out_ch ();

  escaped_frame_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rx_beat_t   stim [$];
  frame_res_t due_results [$];
  int         beats_taken = 0;
  int         mismatches  = 0;
  int         quiet       = 0;
  bit         calm        = 1'b0;
  bit         holding     = 1'b0;

  // Decoder state as the block should hold it.
  bit         frame_open;
  bit         pend_ok;
  bit         esc_armed;
  logic [7:0] pend_byte;
  logic [7:0] body_sum;
  int         hdr_cnt;
  logic [7:0] hdr_buf [efd_pkg::HDR_BYTES];

  function automatic void clear_frame();
    frame_open = 1'b0;
    pend_ok    = 1'b0;
    esc_armed  = 1'b0;
    pend_byte  = 8'h00;
    body_sum   = 8'h00;
    hdr_cnt    = 0;
    foreach (hdr_buf[i]) hdr_buf[i] = 8'h00;
  endfunction

  function automatic logic [7:0] hdr_at(int i);
    return (i < efd_pkg::HDR_BYTES) ? hdr_buf[i] : 8'h00;
  endfunction

  // Advance the decoder by one raw byte; returns 1 when a beat comes out.
  function automatic bit decode_beat(input logic [7:0] b, input logic fin,
                                     output frame_res_t r);
    logic [7:0] raw;
    logic [7:0] dec;
    r.kind            = fin ? efd_pkg::KIND_SUMMARY : efd_pkg::KIND_PAYLOAD;
    r.payload_byte    = 8'h00;
    r.peripheral_id   = hdr_at(0);
    r.protocol_id     = hdr_at(1);
    r.serial_key      = {hdr_at(3), hdr_at(2)};
    r.sequence_number = {hdr_at(5), hdr_at(4)};
    r.message_type    = hdr_at(6);
    r.type_index      = hdr_at(7);
    r.checksum_bad    = 1'b0;
    r.escape_dangling = 1'b0;
    r.too_short       = 1'b0;
    r.last            = fin;
    if (fin) begin
      r.checksum_bad    = pend_ok ? (pend_byte != body_sum) : 1'b1;
      r.escape_dangling = esc_armed;
      r.too_short       = (hdr_cnt < efd_pkg::HDR_BYTES);
      clear_frame();
      return 1'b1;
    end
    if (!frame_open) begin
      frame_open = 1'b1;
      return 1'b0;
    end
    // A new byte proves the held one was body, not the checksum.
    raw       = pend_byte;
    pend_byte = b;
    if (!pend_ok) begin
      pend_ok = 1'b1;
      return 1'b0;
    end
    body_sum = body_sum + raw;
    if (esc_armed) begin
      esc_armed = 1'b0;
      dec = raw - efd_pkg::ESC_OFFSET;
    end else if (raw == efd_pkg::ESC_BYTE) begin
      esc_armed = 1'b1;
      return 1'b0;
    end else begin
      dec = raw;
    end
    if (hdr_cnt < efd_pkg::HDR_BYTES) begin
      hdr_buf[hdr_cnt] = dec;
      hdr_cnt++;
      return 1'b0;
    end
    r.payload_byte = dec;
    return 1'b1;
  endfunction

  function automatic void push_beat(logic [7:0] b, logic fin);
    rx_beat_t t;
    t.rx_byte    = b;
    t.frame_last = fin;
    t.typed      = 1'b0;
    stim.insert(stim.size(), t);
  endfunction

  // Encode n_dec decoded bytes into a frame, optionally ending the body on a
  // bare escape and optionally spoiling the checksum.
  function automatic void add_frame(int n_dec, bit dangle, bit good_sum);
    logic [7:0] d;
    logic [7:0] sum;
    logic [7:0] marker;
    sum = 8'h00;
    marker = 8'($urandom_range(0, 255));
    push_beat(($urandom_range(0, 3) == 0) ? marker : START_MARK, 1'b0);
    for (int i = 0; i < n_dec; i++) begin
      case ($urandom_range(0, 7))
        0: d = efd_pkg::ESC_BYTE;
        1: d = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        default: d = 8'($urandom_range(0, 255));
      endcase
      if (d == efd_pkg::ESC_BYTE || $urandom_range(0, 9) == 0) begin
        sum = sum + efd_pkg::ESC_BYTE;
        push_beat(efd_pkg::ESC_BYTE, 1'b0);
        d = d + efd_pkg::ESC_OFFSET;
      end
      sum = sum + d;
      push_beat(d, 1'b0);
    end
    if (dangle) begin
      sum = sum + efd_pkg::ESC_BYTE;
      push_beat(efd_pkg::ESC_BYTE, 1'b0);
    end
    d = 8'($urandom_range(1, 255));
    push_beat(good_sum ? sum : (sum ^ d), 1'b0);
    marker = 8'($urandom_range(0, 255));
    push_beat(($urandom_range(0, 3) == 0) ? marker : END_MARK, 1'b1);
  endfunction

  // Random raw bytes closed by an end marker; zero bytes is a lone end marker.
  function automatic void add_noise(int n);
    logic [7:0] b;
    for (int i = 0; i <= n; i++) begin
      b = 8'($urandom_range(0, 255));
      push_beat(b, i == n);
    end
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Input side: predict the results of every accepted beat.
  always @(posedge clk) begin
    frame_res_t pred;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (decode_beat(in_ch.rx_byte, in_ch.frame_last, pred)) begin
        if (stim[beats_taken].typed)
          pred = stim[beats_taken].want;
        due_results.insert(due_results.size(), pred);
      end
      beats_taken++;
    end
  end

  // Output side: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    frame_res_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("%0t ns: result beat with nothing expected, kind %0h", $time, out_ch.kind);
      end else begin
        head = due_results.pop_front();
        check_field("kind", 16'(head.kind), 16'(out_ch.kind));
        check_field("payload_byte", 16'(head.payload_byte), 16'(out_ch.payload_byte));
        check_field("peripheral_id", 16'(head.peripheral_id), 16'(out_ch.peripheral_id));
        check_field("protocol_id", 16'(head.protocol_id), 16'(out_ch.protocol_id));
        check_field("serial_key", head.serial_key, out_ch.serial_key);
        check_field("sequence_number", head.sequence_number, out_ch.sequence_number);
        check_field("message_type", 16'(head.message_type), 16'(out_ch.message_type));
        check_field("type_index", 16'(head.type_index), 16'(out_ch.type_index));
        check_field("checksum_bad", 16'(head.checksum_bad), 16'(out_ch.checksum_bad));
        check_field("escape_dangling", 16'(head.escape_dangling),
                    16'(out_ch.escape_dangling));
        check_field("too_short", 16'(head.too_short), 16'(out_ch.too_short));
        check_field("last", 16'(head.last), 16'(out_ch.last));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Sender: offer the raw bytes in order, with random gaps until the tail.
  initial begin : feed
    int k;
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= 8'h00;
    in_ch.frame_last <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (k = 0; k < stim.size(); k++) begin
      calm = (k >= stim.size() - CALM_BEATS);
      if (!calm && !holding && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      in_ch.valid      <= 1'b1;
      in_ch.rx_byte    <= stim[k].rx_byte;
      in_ch.frame_last <= stim[k].frame_last;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
    in_ch.valid <= 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin : drain
    bit held_once;
    held_once = 1'b0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!held_once && beats_taken >= DIR_ROWS + HOLD_AT) begin
        held_once = 1'b1;
        holding   = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : run
    rx_beat_t t;
    dir_row_t row;
    int pick;
    clear_frame();

    // Directed rows, with hand-written summaries where they are obvious.
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      t.rx_byte                = row.rx_byte;
      t.frame_last             = row.frame_last;
      t.typed                  = row.typed;
      t.want.kind              = efd_pkg::KIND_SUMMARY;
      t.want.payload_byte      = 8'h00;
      t.want.peripheral_id     = row.pid;
      t.want.protocol_id       = 8'h00;
      t.want.serial_key        = 16'h0000;
      t.want.sequence_number   = 16'h0000;
      t.want.message_type      = 8'h00;
      t.want.type_index        = 8'h00;
      t.want.checksum_bad      = row.bad_sum;
      t.want.escape_dangling   = row.dangling;
      t.want.too_short         = row.short_hdr;
      t.want.last              = 1'b1;
      stim.insert(stim.size(), t);
    end

    // Random part: mostly well-formed frames, the rest short, dangling or noise.
    while (stim.size() < DIR_ROWS + RAND_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)
        add_frame(efd_pkg::HDR_BYTES + (($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                                   : $urandom_range(0, 16)),
                  1'b0, $urandom_range(0, 6) != 0);
      else if (pick < 78)
        add_frame($urandom_range(0, efd_pkg::HDR_BYTES - 1), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) != 0);
      else if (pick < 86)
        add_frame(efd_pkg::HDR_BYTES + $urandom_range(0, 6), 1'b1,
                  1'($urandom_range(0, 1)));
      else
        add_noise($urandom_range(0, 12));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_taken < stim.size()) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/efd_pkg.sv
hw/rtl/efd_if.sv
hw/rtl/efd_front.sv
hw/rtl/efd_queue.sv
hw/rtl/efd_back.sv
hw/rtl/escaped_frame_decoder.sv
tb/escaped_frame_decoder_test.sv
